@@ design/bfs_pkg.sv @@
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared types, codes and constants of the breadth-first search block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfs_pkg;

	localparam int FUNC_W   = 2;
	localparam int VERTEX_W = 6;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int EDGE_W   = 2 * VERTEX_W;

	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_MAX_EDGES    = 256;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

	localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_VISIT  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_LOAD,
		ST_SCAN,
		ST_EMIT
	} bfs_state_t;

	// datapath conditions seen by the sequencer
	typedef struct packed {
		logic search_go;
		logic scan_done;
		logic slot_free;
		logic queue_empty;
	} bfs_stat_t;

	// sequencer commands to the datapath
	typedef struct packed {
		logic idle;
		logic load_cur;
		logic scan;
		logic emit;
	} bfs_ctrl_t;

endpackage

`default_nettype wire

@@ design/bfs_if.sv @@
// ----------------------------------------------------------------------------
// bfs_if
// Valid/ready channels for the request and result streams.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfs_req_if;
	logic                          valid;
	logic                          ready;
	logic [bfs_pkg::FUNC_W-1:0]    func;
	logic [bfs_pkg::VERTEX_W-1:0]  src_vertex;
	logic [bfs_pkg::VERTEX_W-1:0]  dst_vertex;
	logic [bfs_pkg::VERTEX_W-1:0]  start_vertex;

	modport source (output valid, func, src_vertex, dst_vertex, start_vertex, input ready);
	modport sink   (input valid, func, src_vertex, dst_vertex, start_vertex, output ready);
endinterface

interface bfs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bfs_pkg::VERTEX_W-1:0]  vertex;
	logic [bfs_pkg::STATUS_W-1:0]  status;
	logic                          last;

	modport source (output valid, vertex, status, last, input ready);
	modport sink   (input valid, vertex, status, last, output ready);
endinterface

`default_nettype wire

@@ design/bfs_ram.sv @@
// ----------------------------------------------------------------------------
// bfs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ design/bfs_nbr.sv @@
// ----------------------------------------------------------------------------
// bfs_nbr
// Neighbor compare unit: picks the far end of a stored edge that touches the
// current vertex and checks it against the vertex count and visited map.
// ----------------------------------------------------------------------------
`default_nettype none

module bfs_nbr #(
	parameter int MAX_VERTICES = bfs_pkg::DEF_MAX_VERTICES,
	localparam int VAW = $clog2(MAX_VERTICES)
) (
	input  wire logic [bfs_pkg::EDGE_W-1:0]   edge_data,
	input  wire logic [bfs_pkg::VERTEX_W-1:0] cur,
	input  wire logic [bfs_pkg::COUNT_W-1:0]  n,
	input  wire logic [MAX_VERTICES-1:0]      visited,
	output logic                              hit,
	output logic [bfs_pkg::VERTEX_W-1:0]      nb
);
	import bfs_pkg::*;

	logic [VERTEX_W-1:0] end_a;
	logic [VERTEX_W-1:0] end_b;
	logic                match_a;
	logic                touch;
	logic                in_rng;

	always_comb begin
		end_a   = edge_data[EDGE_W-1:VERTEX_W];
		end_b   = edge_data[VERTEX_W-1:0];
		match_a = (end_a == cur);
		touch   = match_a || (end_b == cur);
		nb      = match_a ? end_b : end_a;
		// drop stale neighbors left from a larger vertex count
		in_rng  = ({1'b0, nb} < n);
		hit     = touch && in_rng && !visited[nb[VAW-1:0]];
	end

endmodule

`default_nettype wire

@@ design/bfs_seq.sv @@
// ----------------------------------------------------------------------------
// bfs_seq
// Sequencer of the search: pop a vertex, scan the edge store, emit a result.
// ----------------------------------------------------------------------------
`default_nettype none

module bfs_seq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bfs_pkg::bfs_stat_t stat,
	output bfs_pkg::bfs_ctrl_t      ctrl
);
	import bfs_pkg::*;

	bfs_state_t state_q;
	bfs_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (stat.search_go) begin
					state_d = ST_POP;
				end
			end
			ST_POP:  state_d = ST_LOAD;
			ST_LOAD: state_d = ST_SCAN;
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.slot_free) begin
					state_d = stat.queue_empty ? ST_IDLE : ST_POP;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.idle     = (state_q == ST_IDLE);
		ctrl.load_cur = (state_q == ST_LOAD);
		ctrl.scan     = (state_q == ST_SCAN);
		ctrl.emit     = (state_q == ST_EMIT) && stat.slot_free;
	end

endmodule

`default_nettype wire

@@ design/breadth_first_search_order.sv @@
// Breadth-first search over an edge list.
// Add, clear and func 3 give no result; a rejected edge or a bad start vertex
// gives its result in the cycle after the transfer.
// A search pops, loads, scans and emits each visited vertex in turn, reading the stored
// edges through the single edge-store read port; input stalls until the last result.
// Reset clears the sequencer, empties the edge store and sets vertex_count 64.
`default_nettype none

module breadth_first_search_order #(
	parameter int MAX_VERTICES = bfs_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = bfs_pkg::DEF_MAX_EDGES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bfs_pkg::COUNT_W-1:0]   cfg_wdata,
	bfs_req_if.sink                            req,
	bfs_rsp_if.source                          rsp
);
	import bfs_pkg::*;

	localparam int TW  = $clog2(MAX_EDGES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int HW  = $clog2(MAX_VERTICES + 1);
	localparam int VAW = $clog2(MAX_VERTICES);

	bfs_stat_t stat;
	bfs_ctrl_t ctrl;

	logic [COUNT_W-1:0]      vertex_count_q;
	logic [COUNT_W-1:0]      n;
	logic [TW-1:0]           total_q;
	logic [TW-1:0]           e_q;
	logic                    edv_s1;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [HW-1:0]           head_q;
	logic [HW-1:0]           tail_q;
	logic [VERTEX_W-1:0]     cur_q;

	logic                    out_valid_q;
	logic [VERTEX_W-1:0]     out_vertex_q;
	logic [STATUS_W-1:0]     out_status_q;
	logic                    out_last_q;

	logic                    req_fire;
	logic                    full;
	logic                    reject;
	logic                    range_err;
	logic                    add_ok;
	logic                    e_lt;
	logic                    hit;
	logic [VERTEX_W-1:0]     nb;
	logic                    enq;
	logic                    load_out;

	logic [EDGE_W-1:0]       edge_rdata;
	logic                    q_we;
	logic [VAW-1:0]          q_waddr;
	logic [VERTEX_W-1:0]     q_wdata;
	logic [VERTEX_W-1:0]     q_rdata;

	// effective vertex count saturates at the graph size
	assign n = (vertex_count_q > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
		: vertex_count_q;

	assign stat.slot_free = !out_valid_q || rsp.ready;
	assign req.ready      = ctrl.idle && stat.slot_free;
	assign req_fire       = req.valid && req.ready;

	assign full      = (total_q == TW'(MAX_EDGES));
	assign reject    = req_fire && (req.func == FUNC_ADD) &&
		(({1'b0, req.src_vertex} >= n) || ({1'b0, req.dst_vertex} >= n) || full);
	assign add_ok    = req_fire && (req.func == FUNC_ADD) && !reject;
	assign range_err = req_fire && (req.func == FUNC_SEARCH) &&
		({1'b0, req.start_vertex} >= n);
	assign stat.search_go = req_fire && (req.func == FUNC_SEARCH) && !range_err;

	assign e_lt             = (e_q < total_q);
	assign stat.scan_done   = !e_lt && !edv_s1;
	assign stat.queue_empty = (head_q >= tail_q);
	assign enq              = edv_s1 && hit;

	bfs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	bfs_ram #(
		.WIDTH (EDGE_W),
		.DEPTH (MAX_EDGES)
	) u_edge_ram (
		.clk   (clk),
		.we    (add_ok),
		.waddr (total_q[EAW-1:0]),
		.wdata ({req.src_vertex, req.dst_vertex}),
		.raddr (e_q[EAW-1:0]),
		.rdata (edge_rdata)
	);

	assign q_we    = stat.search_go || enq;
	assign q_waddr = stat.search_go ? '0 : tail_q[VAW-1:0];
	assign q_wdata = stat.search_go ? req.start_vertex : nb;

	bfs_ram #(
		.WIDTH (VERTEX_W),
		.DEPTH (MAX_VERTICES)
	) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (head_q[VAW-1:0]),
		.rdata (q_rdata)
	);

	bfs_nbr #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_nbr (
		.edge_data (edge_rdata),
		.cur       (cur_q),
		.n         (n),
		.visited   (visited_q),
		.hit       (hit),
		.nb        (nb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= COUNT_RESET;
			total_q        <= '0;
			e_q            <= '0;
			edv_s1         <= 1'b0;
			visited_q      <= '0;
			head_q         <= '0;
			tail_q         <= '0;
		end else begin
			if (cfg_we) begin
				vertex_count_q <= cfg_wdata;
			end

			if (req_fire && (req.func == FUNC_CLEAR)) begin
				total_q <= '0;
			end else if (add_ok) begin
				total_q <= total_q + TW'(1);
			end

			if (ctrl.load_cur) begin
				e_q <= '0;
			end else if (ctrl.scan && e_lt) begin
				e_q <= e_q + TW'(1);
			end
			edv_s1 <= ctrl.scan && e_lt;

			if (stat.search_go) begin
				visited_q <= MAX_VERTICES'(1) << req.start_vertex[VAW-1:0];
				head_q    <= '0;
				tail_q    <= HW'(1);
			end else begin
				if (enq) begin
					visited_q[nb[VAW-1:0]] <= 1'b1;
					tail_q                 <= tail_q + HW'(1);
				end
				if (ctrl.load_cur) begin
					head_q <= head_q + HW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_cur) begin
			cur_q <= q_rdata;
		end
	end

	// result register: holds one transfer while the sink stalls
	assign load_out = ctrl.emit || reject || range_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			out_vertex_q <= cur_q;
			out_status_q <= STAT_VISIT;
			out_last_q   <= stat.queue_empty;
		end else if (load_out) begin
			out_vertex_q <= '0;
			out_status_q <= reject ? STAT_REJECT : STAT_RANGE;
			out_last_q   <= 1'b1;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.vertex = out_vertex_q;
	assign rsp.status = out_status_q;
	assign rsp.last   = out_last_q;

`ifndef SYNTH
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");

	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(MAX_EDGES))
		else $error("edge total above store depth");

	a_search_seed: assert property (@(posedge clk) disable iff (!arst_n)
		stat.search_go |=> $countones(visited_q) == 1)
		else $error("search did not start from a single visited vertex");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit && stat.queue_empty |=> ctrl.idle)
		else $error("sequencer kept running after final result");
`endif

endmodule

`default_nettype wire
